FILE: rtl/core/sce_pkg.sv
package sce_pkg;

  localparam int unsigned MemDepth   = 4096;
  localparam int unsigned IoCount    = 23;
  localparam int unsigned RegCount   = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned MemW       = 20;
  localparam int unsigned PcW        = 12;
  localparam int unsigned IoIdxW     = 5;
  localparam logic [4:0]  IoIdxZero  = 5'd22;
  localparam logic [4:0]  IoIdxReti  = 5'd7;

  typedef enum logic [7:0] {
    OpAdd  = 8'd0,  OpSub  = 8'd1,  OpMul  = 8'd2,  OpAnd  = 8'd3,
    OpOr   = 8'd4,  OpXor  = 8'd5,  OpSll  = 8'd6,  OpSra  = 8'd7,
    OpSrl  = 8'd8,  OpBeq  = 8'd9,  OpBne  = 8'd10, OpBlt  = 8'd11,
    OpBgt  = 8'd12, OpBle  = 8'd13, OpBge  = 8'd14, OpJal  = 8'd15,
    OpLw   = 8'd16, OpSw   = 8'd17, OpReti = 8'd18, OpIn   = 8'd19,
    OpOut  = 8'd20, OpHalt = 8'd21
  } op_e;

  typedef enum logic [1:0] {
    IoNone  = 2'd0,
    IoRead  = 2'd1,
    IoWrite = 2'd2
  } io_acc_e;

  typedef struct packed {
    logic [PcW-1:0]    next_pc;
    logic              halted;
    logic [1:0]        io_access;
    logic [IoIdxW-1:0] io_index;
    logic [DataW-1:0]  io_value;
  } result_t;

endpackage

FILE: rtl/core/sce_dmem.sv
module sce_dmem #(
  parameter int unsigned MEM_DEPTH = sce_pkg::MemDepth,
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [sce_pkg::MemW-1:0] rd_data_o,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [sce_pkg::MemW-1:0] wr_data_i,
  output logic                     clr_busy_o
);

  logic [sce_pkg::MemW-1:0] mem [MEM_DEPTH];
  logic [AW:0]              clr_cnt_q;
  logic                     clr_we;
  logic [AW-1:0]            w_addr;
  logic [sce_pkg::MemW-1:0] w_data;

  assign clr_busy_o = ~clr_cnt_q[AW];
  assign clr_we     = clr_busy_o;
  assign w_addr     = clr_we ? clr_cnt_q[AW-1:0] : wr_addr_i;
  assign w_data     = clr_we ? '0 : wr_data_i;

  // clearing sweep after reset, one word per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy_o) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_we || wr_en_i) begin
      mem[w_addr] <= w_data;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: rtl/core/simple_cpu_execute_unit.sv
// channel  | dir | tdata (low bit up)                                  | tuser
// s_axis   | in  | cmd[7:0] rd[11:8] rs[15:12] rt[19:16] imm[39:20]     | -
// m_axis   | out | pc[11:0] halt[12] io_acc[14:13] io_idx[19:15]       | -
//          |     | io_value[51:20]                                     |
// One beat per cycle back to back while the output register is free: the accept edge
// reads the registers (with write-back forwarding) and the data memory port; the
// write-back edge then computes, writes back and loads the output register.
// After reset the data memory is cleared word by word and no beat is taken.
// A finished result waits in the output register; the next beat is taken
// while it waits, and execution stalls only if it still waits at write back.
module simple_cpu_execute_unit #(
  parameter int unsigned MEM_DEPTH = sce_pkg::MemDepth,
  parameter int unsigned IO_COUNT  = sce_pkg::IoCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // cmd, dest_reg, src_reg_a, src_reg_b, immediate
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // next_pc, halted, io_access, io_index, io_value
);

  localparam int unsigned AW  = $clog2(MEM_DEPTH);
  localparam int unsigned DW  = sce_pkg::DataW;
  localparam int unsigned PW  = sce_pkg::PcW;

  // stage 1 (read) registers, machine state and the output register
  logic              v1_q;
  logic [7:0]        cmd_q;
  logic [3:0]        rd_q, rs_q, rt_q;
  logic [DW-1:0]     a_q, b_q, dv_q;
  logic [DW-1:0]     regs_q [sce_pkg::RegCount];
  logic [DW-1:0]     io_q [IO_COUNT];
  logic [PW-1:0]     pc_q;
  logic              out_v_q;
  sce_pkg::result_t  out_q;

  logic [7:0]        cmd_i;
  logic [3:0]        rd_i, rs_i, rt_i;
  logic [DW-1:0]     imm_i, a_i, b_i, d_i, sum_i;
  logic              s_acc, adv_ok, clr_busy;
  logic [sce_pkg::MemW-1:0] mem_rdata;

  assign cmd_i = s_axis_tdata_i[7:0];
  assign rd_i  = s_axis_tdata_i[11:8];
  assign rs_i  = s_axis_tdata_i[15:12];
  assign rt_i  = s_axis_tdata_i[19:16];
  assign imm_i = {{(DW-20){s_axis_tdata_i[39]}}, s_axis_tdata_i[39:20]};

  // write back fires when stage 1 holds a beat and the output register is free or being taken
  assign adv_ok = v1_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy && (!v1_q || adv_ok);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // write-back values, forwarded into the read of the next beat
  logic [DW-1:0]     wb_val;
  logic              wb_en;
  logic [PW-1:0]     pc_n;
  sce_pkg::result_t  res;

  function automatic logic [DW-1:0] rdf(input logic [3:0] r, input logic [DW-1:0] imm,
                                        input logic fw, input logic [3:0] fr,
                                        input logic [DW-1:0] fv,
                                        input logic [DW-1:0] rv);
    logic [DW-1:0] v;
    if (r == 4'd0) v = '0;
    else if (r == 4'd1) v = imm;
    else if (fw && fr == r) v = fv;
    else v = rv;
    return v;
  endfunction

  assign a_i   = rdf(rs_i, imm_i, wb_en && adv_ok, rd_q, wb_val, regs_q[rs_i]);
  assign b_i   = rdf(rt_i, imm_i, wb_en && adv_ok, rd_q, wb_val, regs_q[rt_i]);
  assign d_i   = rdf(rd_i, imm_i, wb_en && adv_ok, rd_q, wb_val, regs_q[rd_i]);
  assign sum_i = a_i + b_i;

  // memory forwarding: sw in stage 2 vs lw address in stage 1
  logic          sw_en;
  logic [AW-1:0] sw_addr;
  logic [DW-1:0] sum_q;
  logic          fwd_mem_q;
  logic [sce_pkg::MemW-1:0] fwd_data_q, mem_word;

  assign sum_q   = a_q + b_q;
  assign sw_addr = sum_q[AW-1:0];
  assign sw_en   = adv_ok && cmd_q == sce_pkg::OpSw;

  sce_dmem #(.MEM_DEPTH(MEM_DEPTH)) u_dmem (
    .clk_i, .rst_ni,
    .rd_en_i   (s_acc),
    .rd_addr_i (sum_i[AW-1:0]),
    .rd_data_o (mem_rdata),
    .wr_en_i   (sw_en),
    .wr_addr_i (sw_addr),
    .wr_data_i (dv_q[sce_pkg::MemW-1:0]),
    .clr_busy_o(clr_busy)
  );

  assign mem_word = fwd_mem_q ? fwd_data_q : mem_rdata;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q      <= cmd_i;
      rd_q       <= rd_i;
      rs_q       <= rs_i;
      rt_q       <= rt_i;
      a_q        <= a_i;
      b_q        <= b_i;
      dv_q       <= d_i;
      fwd_mem_q  <= sw_en && sw_addr == sum_i[AW-1:0];
      fwd_data_q <= dv_q[sce_pkg::MemW-1:0];
    end
  end

  // execute
  logic [DW-1:0] a, b, prod, t;
  logic [4:0]    n;
  logic [PW-1:0] adv;
  logic [4:0]    idx;
  logic          taken, io_ok;
  assign a    = a_q;
  assign b    = b_q;
  assign n    = b[4:0];
  assign prod = a * b;
  assign adv  = pc_q + ((rd_q == 4'd1 || rs_q == 4'd1 || rt_q == 4'd1) ? PW'(2) : PW'(1));
  assign idx  = sum_q[4:0];
  assign io_ok = idx != sce_pkg::IoIdxZero && 32'(idx) < IO_COUNT;

  always_comb begin
    wb_en = 1'b0;
    wb_val = '0;
    pc_n = pc_q;
    taken = 1'b0;
    t = '0;
    res = '0;
    unique case (cmd_q)
      sce_pkg::OpAdd: begin wb_en = 1'b1; wb_val = a + b; pc_n = adv; end
      sce_pkg::OpSub: begin wb_en = 1'b1; wb_val = a - b; pc_n = adv; end
      sce_pkg::OpMul: begin wb_en = 1'b1; wb_val = prod; pc_n = adv; end
      sce_pkg::OpAnd: begin wb_en = 1'b1; wb_val = a & b; pc_n = adv; end
      sce_pkg::OpOr:  begin wb_en = 1'b1; wb_val = a | b; pc_n = adv; end
      sce_pkg::OpXor: begin wb_en = 1'b1; wb_val = a ^ b; pc_n = adv; end
      sce_pkg::OpSll: begin wb_en = 1'b1; wb_val = a << n; pc_n = adv; end
      sce_pkg::OpSra: begin wb_en = 1'b1; wb_val = $signed(a) >>> n; pc_n = adv; end
      sce_pkg::OpSrl: begin wb_en = 1'b1; wb_val = a >> n; pc_n = adv; end
      sce_pkg::OpBeq, sce_pkg::OpBne, sce_pkg::OpBlt,
      sce_pkg::OpBgt, sce_pkg::OpBle, sce_pkg::OpBge: begin
        unique case (cmd_q)
          sce_pkg::OpBeq: taken = a == b;
          sce_pkg::OpBne: taken = a != b;
          sce_pkg::OpBlt: taken = $signed(a) < $signed(b);
          sce_pkg::OpBgt: taken = $signed(b) < $signed(a);
          sce_pkg::OpBle: taken = !($signed(b) < $signed(a));
          default:        taken = !($signed(a) < $signed(b));
        endcase
        pc_n = taken ? dv_q[PW-1:0] : adv;
      end
      sce_pkg::OpJal: begin
        wb_en = 1'b1; wb_val = DW'(adv);
        // target read after the link write
        pc_n = (rs_q == rd_q && rd_q != 4'd0) ? adv : a[PW-1:0];
      end
      sce_pkg::OpLw: begin
        wb_en = 1'b1;
        wb_val = {{(DW-sce_pkg::MemW){mem_word[sce_pkg::MemW-1]}}, mem_word};
        pc_n = adv;
      end
      sce_pkg::OpSw:   pc_n = adv;
      sce_pkg::OpReti: pc_n = io_q[sce_pkg::IoIdxReti][PW-1:0];
      sce_pkg::OpIn: begin
        t = io_ok ? io_q[idx[$clog2(IO_COUNT)-1:0]] : '0;
        wb_en = 1'b1; wb_val = t; pc_n = adv;
        res.io_access = sce_pkg::IoRead; res.io_index = idx; res.io_value = t;
      end
      sce_pkg::OpOut: begin
        pc_n = adv;
        res.io_access = sce_pkg::IoWrite; res.io_index = idx; res.io_value = dv_q;
      end
      sce_pkg::OpHalt: res.halted = 1'b1;
      default: ;
    endcase
    res.next_pc = pc_n;
    if (rd_q == 4'd0 || rd_q == 4'd1) wb_en = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_ok) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      out_v_q <= 1'b0;
      pc_q    <= '0;
      for (int i = 0; i < sce_pkg::RegCount; i++) regs_q[i] <= '0;
      for (int i = 0; i < IO_COUNT; i++) io_q[i] <= '0;
    end else begin
      if (s_acc) v1_q <= 1'b1;
      else if (adv_ok) v1_q <= 1'b0;
      if (adv_ok) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (adv_ok) pc_q <= pc_n;
      if (adv_ok && wb_en) regs_q[rd_q] <= wb_val;
      if (adv_ok && cmd_q == sce_pkg::OpOut && 32'(idx) < IO_COUNT)
        io_q[idx[$clog2(IO_COUNT)-1:0]] <= dv_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {4'd0, out_q.io_value, out_q.io_index, out_q.io_access,
                            out_q.halted, out_q.next_pc};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready_o) else $error("beat taken during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready_i) |=> $stable(out_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv_ok) |=> v1_q) else $error("stage 1 dropped");

endmodule

FILE: tb/tb_exec_checker.sv
module tb_exec_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o,
  output int unsigned exec_cnt_o,
  output int unsigned halt_cnt_o,
  output int unsigned io_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [sce_pkg::DataW-1:0]   regs [sce_pkg::RegCount];
  logic [sce_pkg::MemW-1:0]    dmem [sce_pkg::MemDepth];
  logic [sce_pkg::DataW-1:0]   io_regs [sce_pkg::IoCount];
  logic [sce_pkg::PcW-1:0]     pc_q;
  sce_pkg::result_t            exp_results[$];

  function automatic logic [31:0] sext20(logic [19:0] v);
    return {{12{v[19]}}, v};
  endfunction

  function automatic void reg_wr(logic [3:0] r, logic [31:0] v);
    if (r != 4'd0) regs[r] = v;
  endfunction

  // executes one instruction against the shadow machine state
  function automatic sce_pkg::result_t execute_instr(logic [39:0] d);
    sce_pkg::op_e  op;
    logic [3:0]  rd, rs, rt;
    logic [31:0] a, b, sum;
    logic [4:0]  n;
    logic [sce_pkg::PcW-1:0] adv, pc;
    logic        br, taken;
    sce_pkg::result_t r;
    op = sce_pkg::op_e'(d[7:0]);
    rd = d[11:8];
    rs = d[15:12];
    rt = d[19:16];
    r = '0;
    taken = 1'b0;
    br = 1'b0;
    regs[0] = '0;
    regs[1] = sext20(d[39:20]);
    a = regs[rs];
    b = regs[rt];
    sum = a + b;
    n = b[4:0];
    adv = (rd == 4'd1 || rs == 4'd1 || rt == 4'd1) ? pc_q + 12'd2 : pc_q + 12'd1;
    pc = pc_q;
    case (op)
      sce_pkg::OpAdd: begin reg_wr(rd, a + b); pc = adv; end
      sce_pkg::OpSub: begin reg_wr(rd, a - b); pc = adv; end
      sce_pkg::OpMul: begin reg_wr(rd, a * b); pc = adv; end
      sce_pkg::OpAnd: begin reg_wr(rd, a & b); pc = adv; end
      sce_pkg::OpOr:  begin reg_wr(rd, a | b); pc = adv; end
      sce_pkg::OpXor: begin reg_wr(rd, a ^ b); pc = adv; end
      sce_pkg::OpSll: begin reg_wr(rd, a << n); pc = adv; end
      sce_pkg::OpSra: begin reg_wr(rd, $unsigned($signed(a) >>> n)); pc = adv; end
      sce_pkg::OpSrl: begin reg_wr(rd, a >> n); pc = adv; end
      sce_pkg::OpBeq: begin br = 1; taken = (a == b); end
      sce_pkg::OpBne: begin br = 1; taken = (a != b); end
      sce_pkg::OpBlt: begin br = 1; taken = $signed(a) < $signed(b); end
      sce_pkg::OpBgt: begin br = 1; taken = $signed(a) > $signed(b); end
      sce_pkg::OpBle: begin br = 1; taken = $signed(a) <= $signed(b); end
      sce_pkg::OpBge: begin br = 1; taken = $signed(a) >= $signed(b); end
      sce_pkg::OpJal: begin
        // link first, then read target (rd == rs sees the link)
        reg_wr(rd, {20'd0, adv});
        pc = regs[rs][sce_pkg::PcW-1:0];
      end
      sce_pkg::OpLw: begin
        reg_wr(rd, sext20(dmem[sum % sce_pkg::MemDepth])); pc = adv;
      end
      sce_pkg::OpSw: begin
        dmem[sum % sce_pkg::MemDepth] = regs[rd][19:0]; pc = adv;
      end
      sce_pkg::OpReti: pc = io_regs[sce_pkg::IoIdxReti][sce_pkg::PcW-1:0];
      sce_pkg::OpIn: begin
        r.io_index = sum[4:0];
        r.io_value = (sum[4:0] == sce_pkg::IoIdxZero || sum[4:0] >= sce_pkg::IoCount) ? '0
                     : io_regs[sum[4:0]];
        reg_wr(rd, r.io_value);
        r.io_access = sce_pkg::IoRead;
        pc = adv;
      end
      sce_pkg::OpOut: begin
        r.io_index = sum[4:0];
        r.io_value = regs[rd];
        if (sum[4:0] < sce_pkg::IoCount) io_regs[sum[4:0]] = r.io_value;
        r.io_access = sce_pkg::IoWrite;
        pc = adv;
      end
      sce_pkg::OpHalt: r.halted = 1'b1;
      default: ;
    endcase
    if (br) pc = taken ? regs[rd][sce_pkg::PcW-1:0] : adv;
    regs[0] = '0;
    pc_q = pc;
    r.next_pc = pc;
    return r;
  endfunction

  assign pending_o = exp_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sce_pkg::result_t got, want;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      foreach (io_regs[i]) io_regs[i] = '0;
      pc_q = '0;
      exp_results.delete();
      err_cnt_o <= 0;
      exec_cnt_o <= 0;
      halt_cnt_o <= 0;
      io_cnt_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        // tdata carries next_pc in the low bits, the struct keeps it on top
        got = sce_pkg::result_t'({m_axis_tdata_i[11:0], m_axis_tdata_i[12],
                                  m_axis_tdata_i[14:13], m_axis_tdata_i[19:15],
                                  m_axis_tdata_i[51:20]});
        if (exp_results.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = exp_results.pop_front();
          if (got !== want || m_axis_tdata_i[55:52] !== 4'd0) begin
            err_cnt_o <= err_cnt_o + 1;
            if (got.next_pc !== want.next_pc)
              $error("next_pc exp %0d got %0d", want.next_pc, got.next_pc);
            if (got.halted !== want.halted)
              $error("halted exp %0d got %0d", want.halted, got.halted);
            if (got.io_access !== want.io_access)
              $error("io_access exp %0d got %0d", want.io_access, got.io_access);
            if (got.io_index !== want.io_index)
              $error("io_index exp %0d got %0d", want.io_index, got.io_index);
            if (got.io_value !== want.io_value)
              $error("io_value exp %h got %h", want.io_value, got.io_value);
            if (m_axis_tdata_i[55:52] !== 4'd0)
              $error("pad bits exp 0 got %h", m_axis_tdata_i[55:52]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = execute_instr(s_axis_tdata_i);
        exp_results.push_back(want);
        exec_cnt_o <= exec_cnt_o + 1;
        if (want.halted) halt_cnt_o <= halt_cnt_o + 1;
        if (want.io_access != sce_pkg::IoNone) io_cnt_o <= io_cnt_o + 1;
      end
    end
  end
endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  int unsigned err_cnt, pending, exec_cnt, halt_cnt, io_cnt;
  int unsigned idle_cycles = 0;
  bit          calm_phase;
  bit          hold_off;
  bit          hold_done;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  simple_cpu_execute_unit DUT (.*);

  tb_exec_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .err_cnt_o(err_cnt), .pending_o(pending), .exec_cnt_o(exec_cnt),
    .halt_cnt_o(halt_cnt), .io_cnt_o(io_cnt)
  );

  function automatic logic [39:0] pack_instr(logic [7:0] op, logic [3:0] rd, logic [3:0] rs,
                                             logic [3:0] rt, logic [19:0] imm);
    return {imm, rt, rs, rd, op};
  endfunction

  // favor small register values and addresses so loads, io and branches hit
  function automatic logic [39:0] rand_instr();
    logic [7:0]  op;
    logic [19:0] imm;
    logic [3:0]  rd;
    op = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(22, 255))
                                      : 8'($urandom_range(0, sce_pkg::OpHalt));
    case ($urandom_range(0, 3))
      0: imm = 20'($urandom);
      1: imm = 20'($urandom_range(0, 40));
      2: imm = 20'hFFFFF - 20'($urandom_range(0, 8));
      default: imm = 20'($urandom_range(0, 4095));
    endcase
    rd = 4'($urandom);
    // keep branches from always jumping far by mixing rd choices
    return pack_instr(op, rd, 4'($urandom), 4'($urandom), imm);
  endfunction

  task automatic send_instr(logic [39:0] d);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (!calm_phase && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= !hold_off && (calm_phase || $urandom_range(0, 99) >= 6);
  end

  initial begin
    hold_off = 1'b0;
    hold_done = 1'b0;
    wait (exec_cnt >= 300);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
    hold_done = 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && idle_cycles > StallLimit + sce_pkg::MemDepth) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    calm_phase = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: build known values, then touch every opcode and corner
    send_instr(pack_instr(sce_pkg::OpAdd, 4'd2, 4'd1, 4'd0, 20'h7FFFF));
    send_instr(pack_instr(sce_pkg::OpAdd, 4'd3, 4'd1, 4'd0, 20'h80000));
    send_instr(pack_instr(sce_pkg::OpSll, 4'd4, 4'd2, 4'd1, 20'd12));
    send_instr(pack_instr(sce_pkg::OpSra, 4'd5, 4'd3, 4'd1, 20'd31));
    send_instr(pack_instr(sce_pkg::OpSrl, 4'd6, 4'd3, 4'd1, 20'd36));
    send_instr(pack_instr(sce_pkg::OpMul, 4'd7, 4'd4, 4'd4, 20'd0));
    send_instr(pack_instr(sce_pkg::OpSub, 4'd8, 4'd0, 4'd2, 20'd0));
    send_instr(pack_instr(sce_pkg::OpAnd, 4'd9, 4'd3, 4'd8, 20'd0));
    send_instr(pack_instr(sce_pkg::OpOr, 4'd10, 4'd2, 4'd3, 20'd0));
    send_instr(pack_instr(sce_pkg::OpXor, 4'd0, 4'd2, 4'd3, 20'd0));
    send_instr(pack_instr(sce_pkg::OpSw, 4'd3, 4'd1, 4'd0, 20'hFFFFF));
    send_instr(pack_instr(sce_pkg::OpLw, 4'd11, 4'd1, 4'd0, 20'hFFFFF));
    send_instr(pack_instr(sce_pkg::OpOut, 4'd2, 4'd1, 4'd0, 20'd7));
    send_instr(pack_instr(sce_pkg::OpOut, 4'd3, 4'd1, 4'd0, 20'd22));
    send_instr(pack_instr(sce_pkg::OpIn, 4'd12, 4'd1, 4'd0, 20'd22));
    send_instr(pack_instr(sce_pkg::OpOut, 4'd2, 4'd1, 4'd0, 20'd31));
    send_instr(pack_instr(sce_pkg::OpIn, 4'd12, 4'd1, 4'd0, 20'd7));
    send_instr(pack_instr(sce_pkg::OpReti, 4'd0, 4'd0, 4'd0, 20'd0));
    send_instr(pack_instr(sce_pkg::OpHalt, 4'd0, 4'd0, 4'd0, 20'd0));
    send_instr(pack_instr(sce_pkg::OpJal, 4'd13, 4'd13, 4'd0, 20'd0));
    for (int k = sce_pkg::OpBeq; k <= sce_pkg::OpBge; k++)
      send_instr(pack_instr(8'(k), 4'd1, 4'd2, 4'd3, 20'h00100));
    send_instr(pack_instr(8'd255, 4'd0, 4'd0, 4'd0, 20'h55555));
    for (int k = 0; k < 700; k++) begin
      calm_phase = (k >= 100 && k < 200);
      send_instr(rand_instr());
    end
    s_axis_tvalid_i <= 1'b0;
    calm_phase = 1'b0;
    while (pending != 0 || !hold_done) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("executed %0d instructions: %0d halts, %0d io accesses, one long output stall",
             exec_cnt, halt_cnt, io_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
